// ===== rtl/snt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor node table package
// Shared types and codes for the sensor node table and its cells.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int unsigned KeyW  = 56;
  localparam int unsigned TimeW = 32;

  typedef enum logic [1:0] {
    ACT_REPORT = 2'd0,
    ACT_SWEEP  = 2'd1,
    ACT_CLEAR  = 2'd2
  } act_e;

  // Action code that carries no meaning; such a request is consumed silently.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_SWEPT    = 3'd3,
    ST_CLEARED  = 3'd4
  } stat_e;

  localparam logic [31:0] ExpireReset = 32'd60000;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [13:0]        humidity;
    logic [6:0]         battery;
    logic signed [7:0]  signal;
    logic [31:0]        boots;
    logic [TimeW-1:0]   stamp;
  } reading_t;

  typedef struct packed {
    logic             active;
    act_e             act;
    logic [TimeW-1:0] now;
    logic [KeyW-1:0]  key;
    reading_t         rd;
    logic             found;
    logic             ins;
  } tok_t;

endpackage

// ===== rtl/snt_in_if.sv =====
// ----------------------------------------------------------------------------
// Sensor node table request channel
// Valid/ready channel that carries one table request.
// ----------------------------------------------------------------------------
interface snt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [31:0]        now_ms;
  logic [7:0]         product_type;
  logic [47:0]        mac_address;
  logic signed [15:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [6:0]         battery_pct;
  logic signed [7:0]  signal_strength;
  logic [31:0]        boot_number;

  modport source (
    output valid, action, now_ms, product_type, mac_address, temperature_centi,
           humidity_centi, battery_pct, signal_strength, boot_number,
    input  ready
  );
  modport sink (
    input  valid, action, now_ms, product_type, mac_address, temperature_centi,
           humidity_centi, battery_pct, signal_strength, boot_number,
    output ready
  );
endinterface

// ===== rtl/snt_out_if.sv =====
// ----------------------------------------------------------------------------
// Sensor node table result channel
// Valid/ready channel that carries one table result.
// ----------------------------------------------------------------------------
interface snt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] slot;
  logic [4:0] valid_count;
  logic [4:0] expired_count;

  modport source (
    output valid, status, slot, valid_count, expired_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot, valid_count, expired_count,
    output ready
  );
endinterface

// ===== rtl/snt_cell.sv =====
// ----------------------------------------------------------------------------
// Sensor node table cell
// Holds one table slot and applies the passing request to it, then hands the
// request and its running counts to the next cell.
// ----------------------------------------------------------------------------
module snt_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5,
  parameter int unsigned IW  = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    expire_ms_i,
  input  snt_pkg::tok_t  tok_i,
  input  logic [IW-1:0]  slot_i,
  input  logic [CW-1:0]  used_i,
  input  logic [CW-1:0]  vcnt_i,
  input  logic [CW-1:0]  ecnt_i,
  output snt_pkg::tok_t  tok_o,
  output logic [IW-1:0]  slot_o,
  output logic [CW-1:0]  used_o,
  output logic [CW-1:0]  vcnt_o,
  output logic [CW-1:0]  ecnt_o
);
  import snt_pkg::*;

  localparam logic [CW-1:0] IdxC = CW'(IDX);
  localparam logic [IW-1:0] IdxS = IW'(IDX);

  logic [KeyW-1:0] key_q;
  reading_t        rd_q;
  logic            valid_q, valid_d;
  tok_t            tok_q, tok_d;
  logic [IW-1:0]   slot_q, slot_d;
  logic [CW-1:0]   used_q, used_d;
  logic [CW-1:0]   vcnt_q, vcnt_d;
  logic [CW-1:0]   ecnt_q, ecnt_d;
  logic            in_use, hit, app, wr, expire, counted;
  logic [TimeW-1:0] age;

  always_comb begin
    in_use  = IdxC < used_i;
    hit     = tok_i.active && (tok_i.act == ACT_REPORT) && !tok_i.found && in_use &&
              (key_q == tok_i.key);
    app     = tok_i.active && (tok_i.act == ACT_REPORT) && !tok_i.found &&
              (used_i == IdxC);
    wr      = hit || app;
    age     = tok_i.now - rd_q.stamp;
    expire  = tok_i.active && (tok_i.act == ACT_SWEEP) && in_use && valid_q &&
              (age > expire_ms_i);

    valid_d = valid_q;
    if (tok_i.active && (tok_i.act == ACT_CLEAR)) begin
      valid_d = 1'b0;
    end else if (wr) begin
      valid_d = 1'b1;
    end else if (expire) begin
      valid_d = 1'b0;
    end

    used_d  = app ? used_i + CW'(1) : used_i;
    counted = valid_d && (IdxC < used_d);
    vcnt_d  = vcnt_i + CW'(counted);
    ecnt_d  = ecnt_i + CW'(expire);
    slot_d  = wr ? IdxS : slot_i;

    tok_d       = tok_i;
    tok_d.found = tok_i.found | wr;
    tok_d.ins   = tok_i.ins | app;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    used_q      <= used_d;
    vcnt_q      <= vcnt_d;
    ecnt_q      <= ecnt_d;
    if (wr) begin
      rd_q <= tok_i.rd;
    end
    if (app) begin
      key_q <= tok_i.key;
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;
  assign used_o = used_q;
  assign vcnt_o = vcnt_q;
  assign ecnt_o = ecnt_q;

endmodule

// ===== rtl/sensor_node_table_with_aging_core.sv =====
// ----------------------------------------------------------------------------
// Sensor node table with aging
// Keyed node table with report upsert, timeout sweep and clear.
// ----------------------------------------------------------------------------
// The table is a chain of MAX_NODES cells, one slot per cell. An accepted
// request enters a head register and then walks the chain one cell per clock,
// so each request passes the head register, every cell, a pending register and
// the output register before its result is visible; requests are handled one
// at a time, and the next request can be taken in the cycle the result appears.
// A new request can be taken while the previous result still waits at the
// output. A request with the unused action code is consumed without a result.
module sensor_node_table_with_aging_core #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  snt_in_if.sink      req_i,
  snt_out_if.source   rsp_o
);
  import snt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [31:0]   expire_q;
  logic [CW-1:0] used_q;
  logic          busy_q;
  tok_t          head_q;
  logic [CW-1:0] head_used_q;

  tok_t          tok  [MAX_NODES+1];
  logic [IW-1:0] slot [MAX_NODES+1];
  logic [CW-1:0] used [MAX_NODES+1];
  logic [CW-1:0] vcnt [MAX_NODES+1];
  logic [CW-1:0] ecnt [MAX_NODES+1];

  logic          pend_q;
  stat_e         pstat_q, pstat_d;
  logic [IW-1:0] pslot_q;
  logic [CW-1:0] pvcnt_q, pecnt_q;

  logic          out_valid_q;
  stat_e         ostat_q;
  logic [IW-1:0] oslot_q;
  logic [CW-1:0] ovcnt_q, oecnt_q;

  logic accept, start, done, load_out;

  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign start       = accept && (req_i.action != ACT_UNUSED);
  assign done        = tok[MAX_NODES].active;
  assign load_out    = pend_q && (!out_valid_q || rsp_o.ready);

  assign tok[0]  = head_q;
  assign slot[0] = '0;
  assign used[0] = head_used_q;
  assign vcnt[0] = '0;
  assign ecnt[0] = '0;

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    snt_cell #(
      .IDX (g),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .expire_ms_i (expire_q),
      .tok_i       (tok[g]),
      .slot_i      (slot[g]),
      .used_i      (used[g]),
      .vcnt_i      (vcnt[g]),
      .ecnt_i      (ecnt[g]),
      .tok_o       (tok[g+1]),
      .slot_o      (slot[g+1]),
      .used_o      (used[g+1]),
      .vcnt_o      (vcnt[g+1]),
      .ecnt_o      (ecnt[g+1])
    );
  end

  always_comb begin
    unique case (tok[MAX_NODES].act)
      ACT_REPORT: begin
        if (!tok[MAX_NODES].found) begin
          pstat_d = ST_DROPPED;
        end else if (tok[MAX_NODES].ins) begin
          pstat_d = ST_INSERTED;
        end else begin
          pstat_d = ST_UPDATED;
        end
      end
      ACT_SWEEP: pstat_d = ST_SWEPT;
      ACT_CLEAR: pstat_d = ST_CLEARED;
      default:   pstat_d = ST_CLEARED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expire_q      <= ExpireReset;
      used_q        <= '0;
      busy_q        <= 1'b0;
      head_q        <= '0;
      head_used_q   <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expire_q <= cfg_wdata_i;
      end
      head_q.active <= start;
      if (start) begin
        head_q.act            <= act_e'(req_i.action);
        head_q.now            <= req_i.now_ms;
        head_q.key            <= {req_i.product_type, req_i.mac_address};
        head_q.rd.temperature <= req_i.temperature_centi;
        head_q.rd.humidity    <= req_i.humidity_centi;
        head_q.rd.battery     <= req_i.battery_pct;
        head_q.rd.signal      <= req_i.signal_strength;
        head_q.rd.boots       <= req_i.boot_number;
        head_q.rd.stamp       <= req_i.now_ms;
        head_q.found          <= 1'b0;
        head_q.ins            <= 1'b0;
        head_used_q           <= (act_e'(req_i.action) == ACT_CLEAR) ? '0 : used_q;
      end
      if (start) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        used_q <= used[MAX_NODES];
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      pstat_q <= pstat_d;
      pslot_q <= (pstat_d == ST_UPDATED || pstat_d == ST_INSERTED) ?
                 slot[MAX_NODES] : '0;
      pvcnt_q <= vcnt[MAX_NODES];
      pecnt_q <= ecnt[MAX_NODES];
    end
    if (load_out) begin
      ostat_q <= pstat_q;
      oslot_q <= pslot_q;
      ovcnt_q <= pvcnt_q;
      oecnt_q <= pecnt_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = ostat_q;
  assign rsp_o.slot          = 4'(oslot_q);
  assign rsp_o.valid_count   = 5'(ovcnt_q);
  assign rsp_o.expired_count = 5'(oecnt_q);

endmodule
